FILE: hw/rtl/navier_stokes_point_residual_assert.svh
// Assertion macros for the point residual pipeline.
`ifndef NAVIER_STOKES_POINT_RESIDUAL_ASSERT_SVH
`define NAVIER_STOKES_POINT_RESIDUAL_ASSERT_SVH

`ifndef SYNTHESIS
`define NSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipeline check failed");
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipeline check failed");
`else
`define NSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/nsr_pkg.sv
// Shared types, constants and saturation helper for the point residual block.
package nsr_pkg;

    localparam int Q_W       = 32;
    localparam int Q_FRAC    = 16;
    localparam int VISC_W    = 31;
    localparam int OPA_W     = Q_W + 1;
    localparam int PROD_W    = OPA_W + Q_W;
    localparam int SUM_W     = Q_W + 3;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_STAGES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_VISCOSITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_TENSOR = 2'd1;

    localparam logic [VISC_W-1:0] VISC_RESET = 31'd65536;

    localparam logic signed [PROD_W-1:0] Q_MAX_W = 65'sd2147483647;
    localparam logic signed [PROD_W-1:0] Q_MIN_W = -65'sd2147483648;

    typedef struct packed {
        logic mul_en;
        logic sat_en;
    } qmul_ctl_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        if (v > Q_MAX_W)
        begin
            return Q_MAX_W[Q_W-1:0];
        end
        else if (v < Q_MIN_W)
        begin
            return Q_MIN_W[Q_W-1:0];
        end
        return v[Q_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/nsr_qmul.sv
// Two-stage Q16.16 multiplier: exact product, then floor and saturate.
module nsr_qmul
    import nsr_pkg::*;
(
    input  logic                    clk,
    input  qmul_ctl_t               ctl,
    input  logic signed [OPA_W-1:0] a,
    input  logic signed [Q_W-1:0]   b,
    output logic signed [Q_W-1:0]   q
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [Q_W-1:0]    q_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);
    // arithmetic shift floors toward minus infinity
    assign q_next    = sat_q(prod_reg >>> Q_FRAC);
    assign q         = q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.sat_en)
        begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: hw/rtl/navier_stokes_point_residual.sv
// Top level: Navier-Stokes weak-form residual at one 2D quadrature point.
//
//  channel | handshake            | words
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | pressure, vel_u, vel_v, gradients, test fn
//  out     | out_valid / out_ready| res_div, res_mom_x, res_mom_y
//  cfg     | cfg_we               | cfg_index, cfg_data (viscosity, full_tensor)
//
// One word per cycle sustained unless out_ready stalls; each word goes through
// two multiply/floor-saturate layers of two stages each, a sum stage and a
// saturate stage. Each stage loads whenever it is empty or the next one moves,
// so bubbles fill under a stall and nothing is lost or repeated.
// Reset clears the stage valid bits and restores the configuration registers.
`include "navier_stokes_point_residual_assert.svh"

module navier_stokes_point_residual
    import nsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VISC_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [Q_W-1:0] pressure,
    input  logic signed [Q_W-1:0] vel_u,
    input  logic signed [Q_W-1:0] vel_v,
    input  logic signed [Q_W-1:0] du_dx,
    input  logic signed [Q_W-1:0] du_dy,
    input  logic signed [Q_W-1:0] dv_dx,
    input  logic signed [Q_W-1:0] dv_dy,
    input  logic signed [Q_W-1:0] test_value,
    input  logic signed [Q_W-1:0] test_dx,
    input  logic signed [Q_W-1:0] test_dy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [Q_W-1:0] res_div,
    output logic signed [Q_W-1:0] res_mom_x,
    output logic signed [Q_W-1:0] res_mom_y
);

    localparam int L1_N = 12;
    localparam int L2_N = 10;

    // configuration
    logic [VISC_W-1:0] visc_reg;
    logic              ft_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visc_reg <= VISC_RESET;
            ft_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VISCOSITY:   visc_reg <= cfg_data;
                CFG_FULL_TENSOR: ft_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // stage control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   en;

    always_comb
    begin
        en[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // first multiply layer
    logic signed [OPA_W-1:0] l1_a [L1_N];
    logic signed [Q_W-1:0]   l1_b [L1_N];
    logic signed [Q_W-1:0]   l1_q [L1_N];
    logic signed [OPA_W-1:0] visc_op;
    qmul_ctl_t               l1_ctl;
    qmul_ctl_t               l2_ctl;

    assign visc_op = $signed({2'b00, visc_reg});
    assign l1_ctl  = '{mul_en: en[0], sat_en: en[1]};
    assign l2_ctl  = '{mul_en: en[2], sat_en: en[3]};

    always_comb
    begin
        l1_a[0]  = visc_op;           l1_b[0]  = du_dx;
        l1_a[1]  = visc_op;           l1_b[1]  = du_dy;
        l1_a[2]  = visc_op;           l1_b[2]  = dv_dx;
        l1_a[3]  = visc_op;           l1_b[3]  = dv_dy;
        l1_a[4]  = OPA_W'(vel_u);     l1_b[4]  = du_dx;
        l1_a[5]  = OPA_W'(vel_v);     l1_b[5]  = du_dy;
        l1_a[6]  = OPA_W'(vel_u);     l1_b[6]  = dv_dx;
        l1_a[7]  = OPA_W'(vel_v);     l1_b[7]  = dv_dy;
        l1_a[8]  = OPA_W'(du_dx);     l1_b[8]  = test_value;
        l1_a[9]  = OPA_W'(dv_dy);     l1_b[9]  = test_value;
        l1_a[10] = OPA_W'(pressure);  l1_b[10] = test_dx;
        l1_a[11] = OPA_W'(pressure);  l1_b[11] = test_dy;
    end

    for (genvar g = 0; g < L1_N; g++)
    begin : g_l1
        nsr_qmul u_qmul (
            .clk (clk),
            .ctl (l1_ctl),
            .a   (l1_a[g]),
            .b   (l1_b[g]),
            .q   (l1_q[g])
        );
    end

    // carry the test function alongside the first layer
    logic signed [Q_W-1:0] tdx0_reg, tdy0_reg, phi0_reg;
    logic signed [Q_W-1:0] tdx1_reg, tdy1_reg, phi1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tdx0_reg <= test_dx;
            tdy0_reg <= test_dy;
            phi0_reg <= test_value;
        end
        if (en[1])
        begin
            tdx1_reg <= tdx0_reg;
            tdy1_reg <= tdy0_reg;
            phi1_reg <= phi0_reg;
        end
    end

    // second multiply layer
    logic signed [OPA_W-1:0] l2_a [L2_N];
    logic signed [Q_W-1:0]   l2_b [L2_N];
    logic signed [Q_W-1:0]   l2_q [L2_N];

    always_comb
    begin
        l2_a[0] = OPA_W'(l1_q[0]);  l2_b[0] = tdx1_reg;
        l2_a[1] = OPA_W'(l1_q[1]);  l2_b[1] = tdy1_reg;
        l2_a[2] = OPA_W'(l1_q[2]);  l2_b[2] = tdy1_reg;
        l2_a[3] = OPA_W'(l1_q[2]);  l2_b[3] = tdx1_reg;
        l2_a[4] = OPA_W'(l1_q[1]);  l2_b[4] = tdx1_reg;
        l2_a[5] = OPA_W'(l1_q[3]);  l2_b[5] = tdy1_reg;
        l2_a[6] = OPA_W'(l1_q[4]);  l2_b[6] = phi1_reg;
        l2_a[7] = OPA_W'(l1_q[5]);  l2_b[7] = phi1_reg;
        l2_a[8] = OPA_W'(l1_q[6]);  l2_b[8] = phi1_reg;
        l2_a[9] = OPA_W'(l1_q[7]);  l2_b[9] = phi1_reg;
    end

    for (genvar g = 0; g < L2_N; g++)
    begin : g_l2
        nsr_qmul u_qmul (
            .clk (clk),
            .ctl (l2_ctl),
            .a   (l2_a[g]),
            .b   (l2_b[g]),
            .q   (l2_q[g])
        );
    end

    // hold the single-product terms while the second layer runs
    logic signed [Q_W-1:0] divx2_reg, divy2_reg, px2_reg, py2_reg;
    logic signed [Q_W-1:0] divx3_reg, divy3_reg, px3_reg, py3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            divx2_reg <= l1_q[8];
            divy2_reg <= l1_q[9];
            px2_reg   <= l1_q[10];
            py2_reg   <= l1_q[11];
        end
        if (en[3])
        begin
            divx3_reg <= divx2_reg;
            divy3_reg <= divy2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
        end
    end

    // exact sums
    logic signed [SUM_W-1:0] sum_div_reg, sum_x_reg, sum_y_reg;
    logic signed [SUM_W-1:0] sum_div_next, sum_x_next, sum_y_next;
    logic signed [SUM_W-1:0] ft_x, ft_y;

    always_comb
    begin
        ft_x = ft_reg ? SUM_W'(l2_q[0]) + SUM_W'(l2_q[2]) : '0;
        ft_y = ft_reg ? SUM_W'(l2_q[4]) + SUM_W'(l2_q[5]) : '0;
        sum_div_next = SUM_W'(divx3_reg) + SUM_W'(divy3_reg);
        sum_x_next   = SUM_W'(l2_q[0]) + SUM_W'(l2_q[1]) + SUM_W'(l2_q[6])
                     + SUM_W'(l2_q[7]) + ft_x - SUM_W'(px3_reg);
        sum_y_next   = SUM_W'(l2_q[3]) + SUM_W'(l2_q[5]) + SUM_W'(l2_q[8])
                     + SUM_W'(l2_q[9]) + ft_y - SUM_W'(py3_reg);
    end

    logic signed [Q_W-1:0] div_reg, mom_x_reg, mom_y_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sum_div_reg <= sum_div_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
        end
        if (en[5])
        begin
            div_reg   <= sat_q(PROD_W'(sum_div_reg));
            mom_x_reg <= sat_q(PROD_W'(sum_x_reg));
            mom_y_reg <= sat_q(PROD_W'(sum_y_reg));
        end
    end

    assign res_div   = div_reg;
    assign res_mom_x = mom_x_reg;
    assign res_mom_y = mom_y_reg;

    // a full pipe under output stall must refuse input
    `NSR_ASSERT_IMPL(a_full_blocks_input, clk, rst_n, (&valid_reg) && !out_ready, !in_ready)
    // a valid sum moves into an empty output stage
    `NSR_ASSERT_NEXT(a_sum_advances, clk, rst_n, valid_reg[4] && !valid_reg[5], valid_reg[5])
    // a blocked sum stage holds its word
    `NSR_ASSERT_NEXT(a_sum_holds, clk, rst_n, valid_reg[4] && !en[5], valid_reg[4] && $stable(sum_x_reg))

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Navier-Stokes point residual block.
module tb;
    import nsr_pkg::*;

    localparam int DIM = 2;
    localparam int QUIET_LIMIT = 2000;
    localparam int WORDS_PER_PHASE = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic signed [Q_W-1:0] Q_HI  = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_LO  = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;

    localparam logic signed [63:0] WIDE_HI = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [Q_W-1:0] pressure;
        logic signed [Q_W-1:0] vel_u;
        logic signed [Q_W-1:0] vel_v;
        logic signed [Q_W-1:0] du_dx;
        logic signed [Q_W-1:0] du_dy;
        logic signed [Q_W-1:0] dv_dx;
        logic signed [Q_W-1:0] dv_dy;
        logic signed [Q_W-1:0] test_value;
        logic signed [Q_W-1:0] test_dx;
        logic signed [Q_W-1:0] test_dy;
    } point_t;

    typedef struct packed {
        logic signed [Q_W-1:0] res_div;
        logic signed [Q_W-1:0] res_mom_x;
        logic signed [Q_W-1:0] res_mom_y;
    } residual_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [VISC_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [Q_W-1:0] pressure = '0;
    logic signed [Q_W-1:0] vel_u = '0;
    logic signed [Q_W-1:0] vel_v = '0;
    logic signed [Q_W-1:0] du_dx = '0;
    logic signed [Q_W-1:0] du_dy = '0;
    logic signed [Q_W-1:0] dv_dx = '0;
    logic signed [Q_W-1:0] dv_dy = '0;
    logic signed [Q_W-1:0] test_value = '0;
    logic signed [Q_W-1:0] test_dx = '0;
    logic signed [Q_W-1:0] test_dy = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [Q_W-1:0] res_div;
    logic signed [Q_W-1:0] res_mom_x;
    logic signed [Q_W-1:0] res_mom_y;

    // Shadow copy of the configuration registers
    logic [VISC_W-1:0] model_visc = VISC_RESET;
    logic              model_full_tensor = 1'b0;

    residual_t residual_q[$];
    point_t    dir_pts[$];
    bit        dir_typed[$];
    residual_t dir_res[$];

    bit idle_on = 1'b1;
    int fail_count = 0;

    navier_stokes_point_residual i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pressure   (pressure),
        .vel_u      (vel_u),
        .vel_v      (vel_v),
        .du_dx      (du_dx),
        .du_dy      (du_dy),
        .dv_dx      (dv_dx),
        .dv_dy      (dv_dy),
        .test_value (test_value),
        .test_dx    (test_dx),
        .test_dy    (test_dy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_div    (res_div),
        .res_mom_x  (res_mom_x),
        .res_mom_y  (res_mom_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > WIDE_HI)
        begin
            return WIDE_HI;
        end
        if (v < WIDE_LO)
        begin
            return WIDE_LO;
        end
        return v;
    endfunction

    // Exact product, floor by 2^16, clamp to 32 bits
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] prod;
        prod = a * b;
        return clamp_q(prod >>> Q_FRAC);
    endfunction

    function automatic residual_t predict_residual(input point_t pt);
        logic signed [63:0] visc, pres, phi, div_sum, acc;
        logic signed [63:0] vel [DIM];
        logic signed [63:0] dphi [DIM];
        logic signed [63:0] grad [DIM][DIM];
        logic signed [63:0] mom [DIM];
        residual_t r;
        int i, j;
        visc = $signed({33'd0, model_visc});
        pres = $signed(pt.pressure);
        phi = $signed(pt.test_value);
        vel[0] = $signed(pt.vel_u);
        vel[1] = $signed(pt.vel_v);
        grad[0][0] = $signed(pt.du_dx);
        grad[0][1] = $signed(pt.du_dy);
        grad[1][0] = $signed(pt.dv_dx);
        grad[1][1] = $signed(pt.dv_dy);
        dphi[0] = $signed(pt.test_dx);
        dphi[1] = $signed(pt.test_dy);
        div_sum = '0;
        for (i = 0; i < DIM; i++)
        begin
            acc = '0;
            div_sum += fx_mul(grad[i][i], phi);
            for (j = 0; j < DIM; j++)
            begin
                acc += fx_mul(fx_mul(visc, grad[i][j]), dphi[j]);
                if (model_full_tensor)
                begin
                    acc += fx_mul(fx_mul(visc, grad[j][i]), dphi[j]);
                end
                acc += fx_mul(fx_mul(vel[j], grad[i][j]), phi);
            end
            acc -= fx_mul(pres, dphi[i]);
            mom[i] = clamp_q(acc);
        end
        div_sum = clamp_q(div_sum);
        r.res_div = div_sum[Q_W-1:0];
        r.res_mom_x = mom[0][Q_W-1:0];
        r.res_mom_y = mom[1][Q_W-1:0];
        return r;
    endfunction

    function automatic point_t mk_pt(input logic signed [Q_W-1:0] p, u, v,
                                     input logic signed [Q_W-1:0] ux, uy, vx, vy,
                                     input logic signed [Q_W-1:0] t, tx, ty);
        point_t pt;
        pt.pressure = p;
        pt.vel_u = u;
        pt.vel_v = v;
        pt.du_dx = ux;
        pt.du_dy = uy;
        pt.dv_dx = vx;
        pt.dv_dy = vy;
        pt.test_value = t;
        pt.test_dx = tx;
        pt.test_dy = ty;
        return pt;
    endfunction

    function automatic residual_t mk_res(input logic signed [Q_W-1:0] d, mx, my);
        residual_t r;
        r.res_div = d;
        r.res_mom_x = mx;
        r.res_mom_y = my;
        return r;
    endfunction

    // Mix of extremes, zero, small-magnitude values and full-range values
    function automatic logic signed [Q_W-1:0] rand_q();
        logic [Q_W-1:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return Q_HI;
            1: return Q_LO;
            2: return '0;
            3, 4, 5, 6: return $signed({{12{raw[19]}}, raw[19:0]});
            default: return $signed(raw);
        endcase
    endfunction

    function automatic point_t rand_point();
        return mk_pt(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                     rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    task automatic add_row(input point_t pt, input bit typed, input residual_t r);
        dir_pts.push_back(pt);
        dir_typed.push_back(typed);
        dir_res.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VISC_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_VISCOSITY: model_visc = data;
            CFG_FULL_TENSOR: model_full_tensor = data[0];
            default: ;
        endcase
    endtask

    task automatic send_point(input point_t pt, input bit typed, input residual_t r);
        in_valid <= 1'b1;
        pressure <= pt.pressure;
        vel_u <= pt.vel_u;
        vel_v <= pt.vel_v;
        du_dx <= pt.du_dx;
        du_dy <= pt.du_dy;
        dv_dx <= pt.dv_dx;
        dv_dy <= pt.dv_dy;
        test_value <= pt.test_value;
        test_dx <= pt.test_dx;
        test_dy <= pt.test_dy;
        do @(posedge clk); while (!in_ready);
        residual_q.push_back(typed ? r : predict_residual(pt));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding word has come back
    task automatic drain_pending();
        in_valid <= 1'b0;
        while (residual_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic signed [Q_W-1:0] want,
                               input logic signed [Q_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin : stimulus
        int k, phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run on the reset configuration
        add_row(mk_pt(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0));
        add_row(mk_pt(0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 0), 1'b1, mk_res(Q_ONE, 0, 0));
        add_row(mk_pt(Q_ONE, 0, 0, 0, 0, 0, 0, 0, Q_ONE, 2 * Q_ONE), 1'b1,
                mk_res(0, -Q_ONE, -2 * Q_ONE));
        add_row(mk_pt(0, 0, 0, 0, Q_ONE, 0, 0, 0, 0, Q_ONE), 1'b1, mk_res(0, Q_ONE, 0));
        add_row(mk_pt(0, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 0), 1'b1, mk_res(0, 0, 0));
        add_row(mk_pt(0, 2 * Q_ONE, 0, 3 * Q_ONE, 0, 0, 0, Q_ONE, 0, 0), 1'b1,
                mk_res(3 * Q_ONE, 6 * Q_ONE, 0));
        // Floor toward minus infinity on a tiny negative product
        add_row(mk_pt(0, 0, 0, -1, 0, 0, 0, 1, 0, 0), 1'b1, mk_res(-1, 0, 0));
        add_row(mk_pt(0, 0, 0, 1, 0, 0, 0, 1, 0, 0), 1'b1, mk_res(0, 0, 0));
        add_row(mk_pt(0, 0, 0, Q_HI, 0, 0, Q_HI, Q_HI, 0, 0), 1'b1, mk_res(Q_HI, 0, 0));
        add_row(mk_pt(0, 0, 0, Q_LO, 0, 0, Q_LO, Q_HI, 0, 0), 1'b1, mk_res(Q_LO, 0, 0));
        add_row(mk_pt(Q_HI, 0, 0, 0, 0, 0, 0, 0, Q_LO, Q_HI), 1'b1,
                mk_res(0, Q_HI, -Q_HI));
        add_row(mk_pt(Q_LO, 0, 0, 0, 0, 0, 0, 0, Q_LO, 0), 1'b1, mk_res(0, -Q_HI, 0));
        add_row(mk_pt(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI),
                1'b0, '0);
        add_row(mk_pt(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO),
                1'b0, '0);
        add_row(mk_pt(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sh5555_5555, 32'shAAAA_AAAA), 1'b0, '0);
        add_row(mk_pt(32'sh0000_8000, -32'sd3, 32'sh0001_4000, 32'sd40000, -32'sd77777,
                      32'sh0002_0001, -32'sh0000_C000, -Q_ONE, 32'sd12345, -32'sd9999),
                1'b0, '0);
        add_row(mk_pt(-32'sh0003_8000, -32'sh0001_0001, 32'sh0000_0003, -32'sh0000_ffff,
                      32'sh0004_0000, -32'sh0002_8000, 32'sh0000_7fff, 32'sh0000_c000,
                      -32'sh0001_8000, 32'sh0002_0000), 1'b0, '0);

        for (k = 0; k < dir_pts.size(); k++)
        begin
            send_point(dir_pts[k], dir_typed[k], dir_res[k]);
        end

        for (phase = 0; phase < 5; phase++)
        begin
            drain_pending();
            case (phase)
                0:
                begin
                    // Zero viscosity leaves only convection and pressure
                    write_reg(CFG_VISCOSITY, '0);
                    write_reg(CFG_FULL_TENSOR, 31'd1);
                end
                1:
                begin
                    // Bits above bit 0 of the tensor flag must be dropped
                    write_reg(CFG_VISCOSITY, '1);
                    write_reg(CFG_FULL_TENSOR, 31'h7FFF_FFFE);
                end
                2:
                begin
                    write_reg(CFG_VISCOSITY, 31'd1);
                    write_reg(CFG_FULL_TENSOR, 31'd1);
                    write_reg(CFG_SPARE_2, VISC_W'($urandom));
                    write_reg(CFG_SPARE_3, '1);
                end
                3:
                begin
                    write_reg(CFG_VISCOSITY, VISC_W'($urandom_range(1, 32'h0004_0000)));
                    write_reg(CFG_FULL_TENSOR, VISC_W'($urandom_range(0, 1)));
                end
                default:
                begin
                    write_reg(CFG_VISCOSITY, 31'd98304);
                    write_reg(CFG_FULL_TENSOR, 31'd1);
                    idle_on = 1'b0;
                end
            endcase
            cfg_we <= 1'b0;
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                send_point(rand_point(), 1'b0, '0);
            end
        end

        drain_pending();
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin : result_monitor
        int stall_left;
        residual_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (residual_q.size() == 0)
                begin
                    $error("unexpected word: div %0d mom_x %0d mom_y %0d",
                           res_div, res_mom_x, res_mom_y);
                    fail_count++;
                end
                else
                begin
                    want = residual_q.pop_front();
                    check_field("res_div", want.res_div, res_div);
                    check_field("res_mom_x", want.res_mom_x, res_mom_x);
                    check_field("res_mom_y", want.res_mom_y, res_mom_y);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

endmodule
